>>> rtl/core/lzwd_pkg.sv
`timescale 1ns / 1ps

package lzwd_pkg;

    localparam int CODE_W   = 12;
    localparam int BYTE_W   = 8;
    localparam int ALPHABET = 256;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_LEAF,
        ST_POP
    } state_t;

    // one dictionary entry: string of prefix followed by suffix
    typedef struct packed {
        logic [CODE_W-1:0] prefix;
        logic [BYTE_W-1:0] suffix;
    } dict_entry_t;

    // one byte waiting on the output stack
    typedef struct packed {
        logic              err;
        logic [BYTE_W-1:0] data;
    } stack_entry_t;

    typedef struct packed {
        logic         en;
        stack_entry_t entry;
    } push_t;

endpackage

>>> rtl/core/lzwd_if.sv
`timescale 1ns / 1ps

interface lzwd_code_if;
    import lzwd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code;

    modport source (output valid, output code, input ready);
    modport sink (input valid, input code, output ready);
endinterface

interface lzwd_byte_if;
    import lzwd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
    logic              error;

    modport source (output valid, output data_byte, output last, output error, input ready);
    modport sink (input valid, input data_byte, input last, input error, output ready);
endinterface

>>> rtl/core/lzw_decoder_unit.sv
`timescale 1ns / 1ps

// channel      dir  beat payload               handshake
// code_stream  in   code[11:0]                 valid/ready
// byte_stream  out  data_byte[7:0] last error  valid/ready
//
// a code is decoded with one dictionary read per chain link, then one stack pop per byte;
// single-byte and rejected codes need no dictionary read
// the dictionary read port (one link a cycle) and the stack read port set the pace with
// one code in flight; the next code is taken once its bytes are all on the way out
// reset clears control only; dictionary and stack are left as they are, no clearing pass
// a stalled byte_stream holds the last beat while the next code is walked

module lzw_decoder_unit #(
    parameter int DICT_ENTRIES = 4096,
    parameter int MAX_STRING   = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    lzwd_code_if.sink   code_stream,
    lzwd_byte_if.source byte_stream
);
    import lzwd_pkg::*;

    localparam int AW    = $clog2(DICT_ENTRIES);
    localparam int NF_W  = $clog2(DICT_ENTRIES + 1);
    localparam int SP_W  = $clog2(MAX_STRING + 1);
    localparam int CMP_W = (NF_W > CODE_W) ? NF_W : CODE_W;

    state_t            state_reg, state_next;
    logic [NF_W-1:0]   next_free_reg, next_free_next;
    logic [CODE_W-1:0] prev_code_reg, prev_code_next;
    logic [BYTE_W-1:0] pfb_reg, pfb_next;
    logic              started_reg, started_next;
    logic [SP_W-1:0]   prev_len_reg, prev_len_next;
    logic              kwk_reg, kwk_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [BYTE_W-1:0] leaf_reg, leaf_next;

    logic              in_fire;
    logic [CMP_W-1:0]  code_ext, nf_ext, rd_code_ext;
    logic              can_add;
    logic              bad;
    logic              kwk;
    logic              prefix_leaf;

    // dictionary port
    logic              dict_wr_en;
    dict_entry_t       dict_wr_data;
    logic              dict_rd_en;
    logic [CODE_W-1:0] rd_code;
    dict_entry_t       dict_rd_data;

    // commit of one accepted code
    logic              commit;
    logic              commit_add;
    logic [CODE_W-1:0] commit_code;
    logic [BYTE_W-1:0] commit_first;

    // output stack
    push_t             push;
    logic              drain;
    logic [SP_W-1:0]   count;

    assign code_stream.ready = (state_reg == ST_IDLE);
    assign in_fire  = code_stream.valid && code_stream.ready;

    assign code_ext    = CMP_W'(code_stream.code);
    assign nf_ext      = CMP_W'(next_free_reg);
    assign rd_code_ext = CMP_W'(rd_code);

    // room in the dictionary and the grown string still fits
    assign can_add = (next_free_reg < NF_W'(DICT_ENTRIES)) &&
                     (prev_len_reg < SP_W'(MAX_STRING));

    // rejected: first code not a plain byte, code beyond the next free entry,
    // or the self-referencing case when nothing may be added
    always_comb
    begin
        if (!started_reg)
        begin
            bad = (code_stream.code >= CODE_W'(ALPHABET));
        end
        else
        begin
            bad = (code_ext > nf_ext) || ((code_ext == nf_ext) && !can_add);
        end
    end

    assign kwk         = started_reg && (code_ext == nf_ext);
    assign prefix_leaf = (dict_rd_data.prefix < CODE_W'(ALPHABET));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (bad || !started_reg)
                    begin
                        state_next = ST_POP;
                    end
                    else if (kwk)
                    begin
                        state_next = (prev_code_reg < CODE_W'(ALPHABET)) ? ST_LEAF : ST_WALK;
                    end
                    else
                    begin
                        state_next = (code_stream.code < CODE_W'(ALPHABET)) ? ST_POP : ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                state_next = prefix_leaf ? ST_LEAF : ST_WALK;
            end
            ST_LEAF:
            begin
                state_next = ST_POP;
            end
            ST_POP:
            begin
                if (count == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        push.en          = 1'b0;
        push.entry.err   = 1'b0;
        push.entry.data  = '0;
        drain            = 1'b0;
        dict_rd_en       = 1'b0;
        rd_code          = code_stream.code;
        commit           = 1'b0;
        commit_add       = 1'b0;
        commit_code      = code_stream.code;
        commit_first     = code_stream.code[BYTE_W-1:0];
        kwk_next         = kwk_reg;
        code_next        = code_reg;
        leaf_next        = leaf_reg;
        started_next     = started_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    code_next = code_stream.code;
                    kwk_next  = kwk;
                    push.en   = 1'b1;
                    if (bad)
                    begin
                        // single error beat, byte zero, nothing else changes
                        push.entry.err = 1'b1;
                    end
                    else if (!started_reg)
                    begin
                        push.entry.data = code_stream.code[BYTE_W-1:0];
                        commit          = 1'b1;
                        started_next    = 1'b1;
                    end
                    else if (kwk)
                    begin
                        // previous string then its own first byte: push the tail first
                        push.entry.data = pfb_reg;
                        rd_code         = prev_code_reg;
                        leaf_next       = prev_code_reg[BYTE_W-1:0];
                        dict_rd_en      = (prev_code_reg >= CODE_W'(ALPHABET));
                    end
                    else if (code_stream.code < CODE_W'(ALPHABET))
                    begin
                        push.entry.data = code_stream.code[BYTE_W-1:0];
                        commit          = 1'b1;
                        commit_add      = can_add;
                    end
                    else
                    begin
                        push.en    = 1'b0;
                        dict_rd_en = 1'b1;
                    end
                end
            end
            ST_WALK:
            begin
                push.en         = 1'b1;
                push.entry.data = dict_rd_data.suffix;
                rd_code         = dict_rd_data.prefix;
                dict_rd_en      = !prefix_leaf;
                leaf_next       = dict_rd_data.prefix[BYTE_W-1:0];
            end
            ST_LEAF:
            begin
                push.en         = 1'b1;
                push.entry.data = leaf_reg;
                commit          = 1'b1;
                commit_add      = can_add;
                commit_code     = code_reg;
                commit_first    = kwk_reg ? pfb_reg : leaf_reg;
            end
            ST_POP:
            begin
                drain = 1'b1;
            end
            default:
            begin
                drain = 1'b0;
            end
        endcase

        next_free_next = next_free_reg;
        prev_code_next = prev_code_reg;
        pfb_next       = pfb_reg;
        prev_len_next  = prev_len_reg;
        if (commit)
        begin
            prev_code_next = commit_code;
            pfb_next       = commit_first;
            // the byte pushed now is the last of this string
            prev_len_next  = count + SP_W'(1);
        end
        if (commit_add)
        begin
            next_free_next = next_free_reg + NF_W'(1);
        end

        dict_wr_en          = commit_add;
        dict_wr_data.prefix = prev_code_reg;
        dict_wr_data.suffix = commit_first;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            next_free_reg <= NF_W'(ALPHABET);
            prev_code_reg <= '0;
            pfb_reg       <= '0;
            started_reg   <= 1'b0;
            prev_len_reg  <= '0;
            kwk_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            prev_code_reg <= prev_code_next;
            pfb_reg       <= pfb_next;
            started_reg   <= started_next;
            prev_len_reg  <= prev_len_next;
            kwk_reg       <= kwk_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        leaf_reg <= leaf_next;
    end

    // walks only read entries below next_free, so the write never meets a pending read
    lzwd_dict_ram #(
        .DEPTH (DICT_ENTRIES),
        .AW    (AW)
    ) u_dict (
        .clk     (clk),
        .wr_en   (dict_wr_en),
        .wr_addr (next_free_reg[AW-1:0]),
        .wr_data (dict_wr_data),
        .rd_en   (dict_rd_en),
        .rd_addr (rd_code_ext[AW-1:0]),
        .rd_data (dict_rd_data)
    );

    // bytes are pushed last first and popped in stream order
    lzwd_emit #(
        .MAX_STRING (MAX_STRING),
        .SP_W       (SP_W)
    ) u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .drain (drain),
        .count (count),
        .dst   (byte_stream)
    );

endmodule

>>> rtl/core/lzwd_dict_ram.sv
`timescale 1ns / 1ps

module lzwd_dict_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  lzwd_pkg::dict_entry_t wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output lzwd_pkg::dict_entry_t rd_data
);
    import lzwd_pkg::*;

    dict_entry_t mem [DEPTH];
    dict_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/lzwd_emit.sv
`timescale 1ns / 1ps

module lzwd_emit #(
    parameter int MAX_STRING = 64,
    parameter int SP_W       = 7
) (
    input  logic            clk,
    input  logic            rst_n,
    input  lzwd_pkg::push_t push,
    input  logic            drain,
    output logic [SP_W-1:0] count,
    lzwd_byte_if.source     dst
);
    import lzwd_pkg::*;

    localparam int IDX_W = (MAX_STRING > 2) ? $clog2(MAX_STRING) : 1;

    stack_entry_t    stack_mem [MAX_STRING];
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [SP_W-1:0] sp_dec;
    logic            rdv_reg, rdv_next;
    logic            ov_reg, ov_next;
    stack_entry_t    rd_entry_reg;
    logic            rd_last_reg;
    stack_entry_t    out_entry_reg;
    logic            out_last_reg;
    logic            load_out;
    logic            issue;

    assign sp_dec   = sp_reg - SP_W'(1);
    // fetch stage moves on when the output slot is free or being taken
    assign load_out = rdv_reg && (!ov_reg || dst.ready);
    assign issue    = drain && (sp_reg != '0) && (!rdv_reg || load_out);

    always_comb
    begin
        sp_next = sp_reg;
        if (push.en)
        begin
            sp_next = sp_reg + SP_W'(1);
        end
        else if (issue)
        begin
            sp_next = sp_dec;
        end

        rdv_next = rdv_reg;
        if (issue)
        begin
            rdv_next = 1'b1;
        end
        else if (load_out)
        begin
            rdv_next = 1'b0;
        end

        ov_next = ov_reg;
        if (load_out)
        begin
            ov_next = 1'b1;
        end
        else if (dst.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg  <= '0;
            rdv_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            sp_reg  <= sp_next;
            rdv_reg <= rdv_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.en)
        begin
            stack_mem[sp_reg[IDX_W-1:0]] <= push.entry;
        end
        if (issue)
        begin
            rd_entry_reg <= stack_mem[sp_dec[IDX_W-1:0]];
            rd_last_reg  <= (sp_reg == SP_W'(1));
        end
        if (load_out)
        begin
            out_entry_reg <= rd_entry_reg;
            out_last_reg  <= rd_last_reg;
        end
    end

    assign count         = sp_reg;
    assign dst.valid     = ov_reg;
    assign dst.data_byte = out_entry_reg.data;
    assign dst.error     = out_entry_reg.err;
    assign dst.last      = out_last_reg;

endmodule

>>> rtl/core/lzwd_checker.sv
`timescale 1ns / 1ps

module lzwd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [lzwd_pkg::CODE_W-1:0] code,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [lzwd_pkg::BYTE_W-1:0] data_byte,
    input logic                        last,
    input logic                        error
);
    import lzwd_pkg::*;

    // a rejected code gives exactly one beat, byte zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last && (data_byte == '0))
    else $error("error beat without last or with nonzero byte");

    // one code at a time: after a code is taken the input side closes
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("second code taken while one is in flight");

    // a stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({data_byte, last, error}))
    else $error("output beat changed under stall");

    // an accepted code word carries no unknown bits
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !$isunknown(code))
    else $error("code beat taken with unknown bits");

endmodule

bind lzw_decoder_unit lzwd_checker u_lzwd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (code_stream.valid),
    .in_ready  (code_stream.ready),
    .code      (code_stream.code),
    .out_valid (byte_stream.valid),
    .out_ready (byte_stream.ready),
    .data_byte (byte_stream.data_byte),
    .last      (byte_stream.last),
    .error     (byte_stream.error)
);
